// ----- rtl/lrut_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the LRU address tracker.
// No dependencies; used by every module in rtl/.
package lrut_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int TAG_BITS_DEF    = 32;

    localparam int CAP_W    = 11;
    localparam int TAG_IN_W = 32;
    localparam int TOTAL_W  = 32;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd1000;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef struct packed {
        logic cmp;
        logic scan;
        logic shift;
    } t_cell_ctl;

endpackage

// ----- rtl/lru_address_tracker.sv -----
`timescale 1ns / 1ps
// Top level of the LRU address tracker: sequencer plus a chain of tag cells.
// Depends on lrut_pkg, lrut_cell and lrut_ctrl.
//
//  channel   handshake                 payload
//  -------   -----------------------   ------------------------------------------
//  request   i_start, o_busy           i_kind, i_tag
//  result    o_valid (one-cycle pulse) o_hit, o_evicted, o_hit_total,
//                                      o_miss_total, o_occupancy
//  config    i_cfg_valid, o_cfg_ready  i_cfg_data (capacity)
//
// An insert goes from accept through S_INS to the result strobe.
// A lookup passes S_CMP, then stays in S_SCAN until the first match reaches cell 0
// or, on a miss, the occupancy is covered; match flags walk one cell per cycle.
// Reset clears occupancy, counters and capacity (to 1000); tag cells are not cleared.
// o_busy is high from the cycle after accept until the result strobe; results
// cannot be stalled.
module lru_address_tracker #(
    parameter int MAX_ENTRIES = lrut_pkg::MAX_ENTRIES_DEF,
    parameter int TAG_BITS    = lrut_pkg::TAG_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_kind,
    input  logic [lrut_pkg::TAG_IN_W-1:0] i_tag,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic                          o_evicted,
    output logic [lrut_pkg::TOTAL_W-1:0]  o_hit_total,
    output logic [lrut_pkg::TOTAL_W-1:0]  o_miss_total,
    output logic [lrut_pkg::CAP_W-1:0]    o_occupancy,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lrut_pkg::CAP_W-1:0]    i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    lrut_pkg::t_cell_ctl ctl;
    logic [TAG_BITS-1:0] key;
    logic [IDX_W-1:0]    limit;
    logic [CNT_W-1:0]    fill;
    logic [TAG_BITS-1:0] tags        [MAX_ENTRIES+1];
    logic                match_flags [MAX_ENTRIES+1];

    assign tags[0]                  = key;
    assign match_flags[MAX_ENTRIES] = 1'b0;

    lrut_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TAG_BITS    (TAG_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_kind       (i_kind),
        .i_tag        (i_tag),
        .o_busy       (o_busy),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_match0     (match_flags[0]),
        .o_ctl        (ctl),
        .o_key        (key),
        .o_limit      (limit),
        .o_fill       (fill),
        .o_valid      (o_valid),
        .o_hit        (o_hit),
        .o_evicted    (o_evicted),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total),
        .o_occupancy  (o_occupancy)
    );

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lrut_cell #(
            .INDEX       (g),
            .MAX_ENTRIES (MAX_ENTRIES),
            .TAG_BITS    (TAG_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_key        (key),
            .i_prev_tag   (tags[g]),
            .i_next_match (match_flags[g+1]),
            .i_limit      (limit),
            .i_fill       (fill),
            .o_tag        (tags[g+1]),
            .o_match      (match_flags[g])
        );
    end

endmodule

// ----- rtl/lrut_cell.sv -----
`timescale 1ns / 1ps
// One entry of the recency chain: tag storage, match compare and match hand-off.
// Depends on lrut_pkg.
module lrut_cell #(
    parameter int INDEX       = 0,
    parameter int MAX_ENTRIES = lrut_pkg::MAX_ENTRIES_DEF,
    parameter int TAG_BITS    = lrut_pkg::TAG_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_ENTRIES),
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                i_clk,
    input  lrut_pkg::t_cell_ctl i_ctl,
    input  logic [TAG_BITS-1:0] i_key,
    input  logic [TAG_BITS-1:0] i_prev_tag,
    input  logic                i_next_match,
    input  logic [IDX_W-1:0]    i_limit,
    input  logic [CNT_W-1:0]    i_fill,
    output logic [TAG_BITS-1:0] o_tag,
    output logic                o_match
);

    logic [TAG_BITS-1:0] r_tag;
    logic                r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && (IDX_W'(INDEX) <= i_limit)) begin
            r_tag <= i_prev_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= (CNT_W'(INDEX) < i_fill) && (r_tag == i_key);
        end else if (i_ctl.scan) begin
            r_match <= i_next_match;
        end
    end

    assign o_tag   = r_tag;
    assign o_match = r_match;

endmodule

// ----- rtl/lrut_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the recency chain: request intake, match scan, counters, result.
// Depends on lrut_pkg.
module lrut_ctrl #(
    parameter int MAX_ENTRIES = lrut_pkg::MAX_ENTRIES_DEF,
    parameter int TAG_BITS    = lrut_pkg::TAG_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_ENTRIES),
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_kind,
    input  logic [lrut_pkg::TAG_IN_W-1:0] i_tag,
    output logic                          o_busy,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lrut_pkg::CAP_W-1:0]    i_cfg_data,
    input  logic                          i_match0,
    output lrut_pkg::t_cell_ctl           o_ctl,
    output logic [TAG_BITS-1:0]           o_key,
    output logic [IDX_W-1:0]              o_limit,
    output logic [CNT_W-1:0]              o_fill,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic                          o_evicted,
    output logic [lrut_pkg::TOTAL_W-1:0]  o_hit_total,
    output logic [lrut_pkg::TOTAL_W-1:0]  o_miss_total,
    output logic [lrut_pkg::CAP_W-1:0]    o_occupancy
);

    localparam int CMP_W = (CNT_W > lrut_pkg::CAP_W) ? CNT_W : lrut_pkg::CAP_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_SCAN = 2'd3;

    logic [1:0]                   r_state;
    logic [TAG_BITS-1:0]          r_key;
    logic [CNT_W-1:0]             r_fill;
    logic [CNT_W-1:0]             r_k;
    logic [lrut_pkg::CAP_W-1:0]   r_cap;
    logic [lrut_pkg::TOTAL_W-1:0] r_hit_cnt;
    logic [lrut_pkg::TOTAL_W-1:0] r_miss_cnt;
    logic                         r_valid;
    logic                         r_hit;
    logic                         r_evicted;

    logic             accept;
    logic             scan_hit;
    logic             scan_miss;
    logic             evict;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;

    assign accept    = i_start && (r_state == S_IDLE);
    assign scan_miss = (r_state == S_SCAN) && (r_k == r_fill);
    assign scan_hit  = (r_state == S_SCAN) && (r_k != r_fill) && i_match0;

    always_comb begin
        cap_ext = CMP_W'(r_cap);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        evict = CMP_W'(r_fill) >= eff_cap;
    end

    always_comb begin
        o_ctl.cmp   = (r_state == S_CMP);
        o_ctl.scan  = (r_state == S_SCAN) && !scan_hit && !scan_miss;
        o_ctl.shift = (r_state == S_INS) || scan_hit;
        o_limit     = (r_state == S_INS) ? IDX_W'(MAX_ENTRIES - 1) : r_k[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_cap      <= lrut_pkg::CAPACITY_RESET;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= (i_kind == lrut_pkg::KIND_INSERT) ? S_INS : S_CMP;
                    end
                end
                S_INS: begin
                    if (!evict) begin
                        r_fill <= CNT_W'(r_fill + CNT_W'(1));
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_CMP: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        if (r_hit_cnt != '1) begin
                            r_hit_cnt <= r_hit_cnt + lrut_pkg::TOTAL_W'(1);
                        end
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (scan_miss) begin
                        if (r_miss_cnt != '1) begin
                            r_miss_cnt <= r_miss_cnt + lrut_pkg::TOTAL_W'(1);
                        end
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= TAG_BITS'(i_tag);
        end
        if (r_state == S_CMP) begin
            r_k <= '0;
        end else if (o_ctl.scan) begin
            r_k <= CNT_W'(r_k + CNT_W'(1));
        end
        r_hit     <= scan_hit;
        r_evicted <= (r_state == S_INS) && evict;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_key        = r_key;
    assign o_fill       = r_fill;
    assign o_valid      = r_valid;
    assign o_hit        = r_hit;
    assign o_evicted    = r_evicted;
    assign o_hit_total  = r_hit_cnt;
    assign o_miss_total = r_miss_cnt;
    assign o_occupancy  = lrut_pkg::CAP_W'(CMP_W'(r_fill));

endmodule
